// ----- rtl/core/sfq_pkg.sv -----
// Shared types and codes for the sorted flow-size priority queue.
// No dependencies; imported by sfq_ctrl, sfq_dpath and the top level.
package sfq_pkg;

	localparam int KEY_W = 32;
	localparam int HND_W = 16;
	localparam int OCC_W = 5;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		logic    load;
		logic    push;
		logic    pop;
		logic    head_sel;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} stat_t;

endpackage

// ----- rtl/core/sfq_ctrl.sv -----
// Controller for the sorted flow-size priority queue: handshake and op decode.
// Depends on sfq_pkg; drives sfq_dpath through cmd_t, reads stat_t.
module sfq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sfq_pkg::op_t    op,
	output logic            out_valid,
	input  logic            out_ready,
	input  sfq_pkg::stat_t  stat,
	output sfq_pkg::cmd_t   cmd
);
	import sfq_pkg::*;

	typedef enum logic {
		S_EMPTY,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready  = (state_q == S_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.status   = ST_OK;
		unique case (op)
			OP_ENQ: begin
				cmd.push   = accept && !stat.full;
				cmd.status = stat.full ? ST_FULL : ST_OK;
			end
			OP_DEQ, OP_PEEK, OP_REMOVE: begin
				if (stat.empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.head_sel = 1'b1;
					cmd.pop      = accept && (op != OP_PEEK);
				end
			end
			default: cmd.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else if (accept) begin
			state_q <= S_HOLD;
		end else if (out_ready) begin
			state_q <= S_EMPTY;
		end
	end

endmodule

// ----- rtl/core/sfq_dpath.sv -----
// Datapath: sorted shift-register chain, entry count, capacity and result register.
// Depends on sfq_pkg; commanded by sfq_ctrl.
module sfq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfq_pkg::cmd_t               cmd,
	output sfq_pkg::stat_t              stat,
	input  logic                        has_tag,
	input  logic [sfq_pkg::KEY_W-1:0]   key_in,
	input  logic [sfq_pkg::HND_W-1:0]   handle,
	input  logic                        cap_we,
	input  logic [sfq_pkg::CAP_W-1:0]   cap_wdata,
	output sfq_pkg::status_t            status,
	output logic [sfq_pkg::HND_W-1:0]   out_handle,
	output logic [sfq_pkg::KEY_W-1:0]   out_key,
	output logic [sfq_pkg::OCC_W-1:0]   occupancy
);
	import sfq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;
	localparam int EW = (MW > OCC_W) ? MW : OCC_W;

	logic [KEY_W-1:0] key_q [DEPTH];
	logic [HND_W-1:0] hnd_q [DEPTH];
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_nx;
	logic [CAP_W-1:0] cap_q;
	logic [KEY_W-1:0] new_key;
	logic [DEPTH-1:0] le;
	logic [EW-1:0]    cnt_ext;

	status_t          status_q;
	logic [HND_W-1:0] out_hnd_q;
	logic [KEY_W-1:0] out_key_q;
	logic [OCC_W-1:0] occ_q;

	assign new_key    = has_tag ? key_in : '0;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (MW'(cnt_q) >= MW'(cap_q)) || (cnt_q == CW'(DEPTH));

	always_comb begin
		cnt_nx = cnt_q;
		if (cmd.push) begin
			cnt_nx = cnt_q + 1'b1;
		end else if (cmd.pop) begin
			cnt_nx = cnt_q - 1'b1;
		end
	end

	assign cnt_ext = EW'(cnt_nx);

	// entries at or before the insertion point: a prefix, since the chain is sorted
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign le[i] = (CW'(i) < cnt_q) && (key_q[i] <= new_key);

		always_ff @(posedge clk) begin
			if (cmd.push && !le[i]) begin
				if (i == 0) begin
					key_q[i] <= new_key;
					hnd_q[i] <= handle;
				end else if (le[(i == 0) ? 0 : i-1]) begin
					key_q[i] <= new_key;
					hnd_q[i] <= handle;
				end else begin
					key_q[i] <= key_q[(i == 0) ? 0 : i-1];
					hnd_q[i] <= hnd_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.pop && (i < DEPTH - 1)) begin
				key_q[i] <= key_q[(i < DEPTH - 1) ? i+1 : i];
				hnd_q[i] <= hnd_q[(i < DEPTH - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			cnt_q <= cnt_nx;
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q  <= cmd.status;
			out_hnd_q <= cmd.head_sel ? hnd_q[0] : '0;
			out_key_q <= cmd.head_sel ? key_q[0] : '0;
			occ_q     <= cnt_ext[OCC_W-1:0];
		end
	end

	assign status     = status_q;
	assign out_handle = out_hnd_q;
	assign out_key    = out_key_q;
	assign occupancy  = occ_q;

endmodule

// ----- rtl/core/sorted_flow_size_priority_queue.sv -----
// Sorted flow-size priority queue: shortest flow key at the head, ties in arrival order.
// The result of each accepted item is registered in the output register.
// Throughput: 1 item per cycle while m_tready takes each result; every entry compares against the new key in parallel.
// The output register holds a result until taken; a new item enters as it leaves.
// Reset (arst_n, async, low) empties the queue and sets capacity to 16; no clearing pass.
// Depends on sfq_pkg, sfq_ctrl, sfq_dpath.
module sorted_flow_size_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // key[31:0], handle[47:32]
	input  logic [2:0]  s_tuser,   // op[1:0], has_tag[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_handle[15:0], out_key[47:16], occupancy[52:48]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // capacity
);
	import sfq_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	op_t              op;
	status_t          status;
	logic [HND_W-1:0] out_handle;
	logic [KEY_W-1:0] out_key;
	logic [OCC_W-1:0] occupancy;

	assign op        = op_t'(s_tuser[1:0]);
	assign cfg_ready = 1'b1;

	sfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.has_tag    (s_tuser[2]),
		.key_in     (s_tdata[31:0]),
		.handle     (s_tdata[47:32]),
		.cap_we     (cfg_valid),
		.cap_wdata  (cfg_data),
		.status     (status),
		.out_handle (out_handle),
		.out_key    (out_key),
		.occupancy  (occupancy)
	);

	assign m_tdata = {3'b000, occupancy, out_key, out_handle};
	assign m_tuser = status;

endmodule
